/* sv/hrma_pkg.sv */
// ----------------------------------------------------------------------------
// hrma_pkg
// Shared types and constants for the heart-rate moving average block:
// controller states, command and status groups, divider widths.
// ----------------------------------------------------------------------------
package hrma_pkg;

    // Payload and register widths
    localparam int unsigned INTERVAL_W = 16;
    localparam int unsigned PERIOD_W   = 10;
    localparam int unsigned RATE_W     = 16;
    localparam int unsigned PROD_W     = INTERVAL_W + PERIOD_W;

    // Divider widths: numerator 1200000 + 11*d < 2^30, denominator 20*d < 2^31
    localparam int unsigned NUM_W     = 30;
    localparam int unsigned DEN_W     = 31;
    localparam int unsigned DIV_CNT_W = 5;

    localparam logic [PERIOD_W-1:0] PERIOD_RESET  = 10'd10;
    localparam logic [RATE_W-1:0]   RATE_MAX      = 16'd60000;
    localparam logic [NUM_W-1:0]    RATE_NUM_BASE = 30'd1200000;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_RATE_GO,
        ST_RATE_DIV,
        ST_UPDATE,
        ST_FINISH
    } hrma_state_t;

    typedef struct packed {
        logic load_in;
        logic mul;
        logic div_start;
        logic update;
        logic out_load;
    } hrma_cmd_t;

    typedef struct packed {
        logic div_done;
    } hrma_sts_t;

endpackage

/* sv/hrma_div.sv */
// ----------------------------------------------------------------------------
// hrma_div
// Restoring radix-2 divider, one quotient bit per cycle. Computes the
// rounded beat rate.
// ----------------------------------------------------------------------------
module hrma_div
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [hrma_pkg::NUM_W-1:0]    num,
    input  logic [hrma_pkg::DEN_W-1:0]    den,
    output logic [hrma_pkg::NUM_W-1:0]    quo,
    output logic                          done
);

    logic [hrma_pkg::DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                           done_reg, done_next;
    logic [hrma_pkg::NUM_W-1:0]     quo_reg, quo_next;
    logic [hrma_pkg::DEN_W-1:0]     rem_reg, rem_next;
    logic [hrma_pkg::DEN_W:0]       trial;
    logic                           ge;

    // One restoring step: shift in the next numerator bit, subtract if it fits
    always_comb
    begin
        trial = {rem_reg, quo_reg[hrma_pkg::NUM_W-1]};
        ge    = (trial >= {1'b0, den});
    end

    always_comb
    begin
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        done_next = 1'b0;
        if (start)
        begin
            cnt_next = hrma_pkg::DIV_CNT_W'(hrma_pkg::NUM_W);
            quo_next = num;
            rem_next = '0;
        end
        else if (cnt_reg != '0)
        begin
            cnt_next  = cnt_reg - 1'b1;
            quo_next  = {quo_reg[hrma_pkg::NUM_W-2:0], ge};
            rem_next  = ge ? hrma_pkg::DEN_W'(trial - {1'b0, den})
                           : trial[hrma_pkg::DEN_W-1:0];
            done_next = (cnt_reg == hrma_pkg::DIV_CNT_W'(1));
        end
    end

    // Hold iteration count and completion flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    // Advance partial remainder and quotient
    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
    end

    assign quo  = quo_reg;
    assign done = done_reg;

    // Done is a single-cycle pulse
    a_done_pulse : assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg)
        else $error("divider done held for more than one cycle");

    // No restart while a division is in flight
    a_no_restart : assert property (@(posedge clk) disable iff (!rst_n)
        start |-> (cnt_reg == '0))
        else $error("divider started while busy");

endmodule

/* sv/hrma_dp.sv */
// ----------------------------------------------------------------------------
// hrma_dp
// Datapath: period register, interval product, rate numerator/denominator,
// serial rate divider, rate ring with running total, reciprocal-multiply
// mean and the output register.
// ----------------------------------------------------------------------------
module hrma_dp
#(
    parameter int unsigned WINDOW_SIZE = 8
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [hrma_pkg::PERIOD_W-1:0]       cfg_wdata,
    input  logic [hrma_pkg::INTERVAL_W-1:0]     interval_samples,
    input  hrma_pkg::hrma_cmd_t                 cmd,
    output hrma_pkg::hrma_sts_t                 sts,
    output logic [hrma_pkg::RATE_W-1:0]         avg_bpm,
    output logic                                zero_interval
);

    localparam int unsigned SLOT_W  = (WINDOW_SIZE > 1) ? $clog2(WINDOW_SIZE) : 1;
    localparam int unsigned TOTAL_W = hrma_pkg::RATE_W + $clog2(WINDOW_SIZE);
    localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(WINDOW_SIZE - 1);
    localparam logic [TOTAL_W:0]  TOTAL_MAX = (TOTAL_W + 1)'(WINDOW_SIZE * 60000);

    // Scaled reciprocal of the window: floor(total * K / 2^MEAN_SH) is the
    // exact floor of total / WINDOW_SIZE for every total below 2^TOTAL_W
    localparam int unsigned     MEAN_SH    = TOTAL_W + $clog2(WINDOW_SIZE);
    localparam int unsigned     MEAN_K_W   = TOTAL_W + 1;
    localparam longint unsigned MEAN_K_VAL =
        ((64'd1 << MEAN_SH) + WINDOW_SIZE - 1) / WINDOW_SIZE;
    localparam logic [MEAN_K_W-1:0] MEAN_K = MEAN_K_W'(MEAN_K_VAL);

    logic [hrma_pkg::PERIOD_W-1:0]   period_reg;
    logic [hrma_pkg::INTERVAL_W-1:0] interval_reg;
    logic [hrma_pkg::PROD_W-1:0]     prod_reg;
    logic                            zero_reg;
    logic [SLOT_W-1:0]               slot_reg, slot_next;
    logic [TOTAL_W-1:0]              total_reg, total_next;
    logic [WINDOW_SIZE-1:0]          vld_reg;
    logic [hrma_pkg::RATE_W-1:0]     old_rate_reg;
    logic [hrma_pkg::RATE_W-1:0]     avg_reg;
    logic                            zero_out_reg;
    logic [hrma_pkg::RATE_W-1:0]     ring_mem [WINDOW_SIZE];

    logic [hrma_pkg::NUM_W-1:0]      rate_num;
    logic [hrma_pkg::DEN_W-1:0]      rate_den;
    logic [hrma_pkg::NUM_W-1:0]      div_quo;
    logic                            div_done;
    logic [hrma_pkg::RATE_W-1:0]     rate;
    logic [TOTAL_W+MEAN_K_W-1:0]     mean_prod;
    logic [hrma_pkg::RATE_W-1:0]     mean;

    // Sample period register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            period_reg <= hrma_pkg::PERIOD_RESET;
        else if (cfg_we)
            period_reg <= cfg_wdata;
    end

    // Capture the interval, fetch the oldest ring entry, form the product
    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            interval_reg <= interval_samples;
            old_rate_reg <= vld_reg[slot_reg] ? ring_mem[slot_reg] : '0;
        end
        if (cmd.mul)
        begin
            prod_reg <= interval_reg * period_reg;
            zero_reg <= (interval_reg == '0);
        end
    end

    // Numerator 1200000 + 11*d and denominator 20*d by shift-and-add
    always_comb
    begin
        rate_num = hrma_pkg::RATE_NUM_BASE
                 + (hrma_pkg::NUM_W'(prod_reg) << 3)
                 + (hrma_pkg::NUM_W'(prod_reg) << 1)
                 + hrma_pkg::NUM_W'(prod_reg);
        rate_den = (hrma_pkg::DEN_W'(prod_reg) << 4)
                 + (hrma_pkg::DEN_W'(prod_reg) << 2);
    end

    hrma_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_start),
        .num   (rate_num),
        .den   (rate_den),
        .quo   (div_quo),
        .done  (div_done)
    );

    assign sts.div_done = div_done;

    // Clamp the rate; a zero product divides by zero and clamps to the maximum
    always_comb
    begin
        if (div_quo > hrma_pkg::NUM_W'(hrma_pkg::RATE_MAX))
            rate = hrma_pkg::RATE_MAX;
        else
            rate = div_quo[hrma_pkg::RATE_W-1:0];
    end

    // Running total and write slot
    always_comb
    begin
        total_next = total_reg;
        slot_next  = slot_reg;
        if (cmd.update)
        begin
            total_next = total_reg - TOTAL_W'(old_rate_reg) + TOTAL_W'(rate);
            slot_next  = (slot_reg == SLOT_LAST) ? '0 : slot_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg <= '0;
            slot_reg  <= '0;
            vld_reg   <= '0;
        end
        else
        begin
            total_reg <= total_next;
            slot_reg  <= slot_next;
            if (cmd.update)
                vld_reg[slot_reg] <= 1'b1;
        end
    end

    // Ring store write
    always_ff @(posedge clk)
    begin
        if (cmd.update)
            ring_mem[slot_reg] <= rate;
    end

    // Truncated mean: multiply by the reciprocal, drop the fraction bits
    always_comb
    begin
        mean_prod = total_reg * MEAN_K;
        mean      = hrma_pkg::RATE_W'(mean_prod >> MEAN_SH);
    end

    // Output register, loaded with the mean of the updated ring
    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            avg_reg      <= mean;
            zero_out_reg <= zero_reg;
        end
    end

    assign avg_bpm       = avg_reg;
    assign zero_interval = zero_out_reg;

    // Running total never exceeds a full window of maximum rates
    a_total_bound : assert property (@(posedge clk) disable iff (!rst_n)
        ({1'b0, total_reg} <= TOTAL_MAX))
        else $error("ring total out of range");

endmodule

/* sv/hrma_ctrl.sv */
// ----------------------------------------------------------------------------
// hrma_ctrl
// Controller: sequences capture, multiply, rate division, ring update
// and output load; owns both handshakes.
// ----------------------------------------------------------------------------
module hrma_ctrl
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_stall,
    output logic                    out_valid,
    input  logic                    out_stall,
    input  hrma_pkg::hrma_sts_t     sts,
    output hrma_pkg::hrma_cmd_t     cmd
);

    hrma_pkg::hrma_state_t state_reg, state_next;
    logic                  out_valid_reg, out_valid_next;
    logic                  out_free;

    assign out_free = !out_valid_reg || !out_stall;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            hrma_pkg::ST_IDLE:
                if (in_valid)
                    state_next = hrma_pkg::ST_MUL;
            hrma_pkg::ST_MUL:
                state_next = hrma_pkg::ST_RATE_GO;
            hrma_pkg::ST_RATE_GO:
                state_next = hrma_pkg::ST_RATE_DIV;
            hrma_pkg::ST_RATE_DIV:
                if (sts.div_done)
                    state_next = hrma_pkg::ST_UPDATE;
            hrma_pkg::ST_UPDATE:
                state_next = hrma_pkg::ST_FINISH;
            hrma_pkg::ST_FINISH:
                if (out_free)
                    state_next = hrma_pkg::ST_IDLE;
            default:
                state_next = hrma_pkg::ST_IDLE;
        endcase
    end

    // Outputs
    always_comb
    begin
        cmd      = '0;
        in_stall = 1'b1;
        case (state_reg)
            hrma_pkg::ST_IDLE:
            begin
                in_stall    = 1'b0;
                cmd.load_in = in_valid;
            end
            hrma_pkg::ST_MUL:
                cmd.mul = 1'b1;
            hrma_pkg::ST_RATE_GO:
                cmd.div_start = 1'b1;
            hrma_pkg::ST_UPDATE:
                cmd.update = 1'b1;
            hrma_pkg::ST_FINISH:
                cmd.out_load = out_free;
            default:
                cmd = '0;
        endcase
    end

    // Hold a result until its transfer, load a new one when the slot frees
    always_comb
    begin
        out_valid_next = out_valid_reg && out_stall;
        if (cmd.out_load)
            out_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= hrma_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

    // An input transfer always starts the multiply step
    a_accept_mul : assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> (state_reg == hrma_pkg::ST_MUL))
        else $error("input transfer did not start processing");

    // A result is never loaded over one still waiting
    a_no_overwrite : assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!out_valid_reg || !out_stall))
        else $error("output register overwritten");

endmodule

/* sv/heart_rate_moving_average.sv */
// ----------------------------------------------------------------------------
// heart_rate_moving_average
// Turns beat intervals into rounded beats per minute and outputs the
// truncated mean of the last WINDOW_SIZE rates.
//
//   Channel  Direction  Handshake            Payload
//   input    in         in_valid / in_stall  interval_samples[15:0]
//   output   out        out_valid/out_stall  avg_bpm[15:0], zero_interval
//   config   in         cfg_we               cfg_wdata[9:0] (sample period)
//
// An item passes from input transfer through the multiply step, the serial
// rate divider, the ring update and the output load step; the mean is a
// constant reciprocal multiply in the output load step.
// One item is in work at a time; a stalled result holds the next item in
// its final step.
// Reset clears the ring through per-entry valid bits; no clearing pass.
// ----------------------------------------------------------------------------
module heart_rate_moving_average
#(
    parameter int unsigned WINDOW_SIZE = 8
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [9:0]  cfg_wdata,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [15:0] interval_samples,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [15:0] avg_bpm,
    output logic        zero_interval
);

    hrma_pkg::hrma_cmd_t cmd;
    hrma_pkg::hrma_sts_t sts;

    hrma_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    hrma_dp #(
        .WINDOW_SIZE (WINDOW_SIZE)
    ) u_dp
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_we           (cfg_we),
        .cfg_wdata        (cfg_wdata),
        .interval_samples (interval_samples),
        .cmd              (cmd),
        .sts              (sts),
        .avg_bpm          (avg_bpm),
        .zero_interval    (zero_interval)
    );

endmodule

/* tb/heart_rate_moving_average_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// heart_rate_moving_average_tb
// Self-checking bench for the heart-rate moving average. Beat intervals are
// driven through the valid/stall input channel. A scoreboard predicts the
// rounded rate, the ring of recent rates and its truncated mean for every
// transfer, and checks each output transfer against the oldest prediction.
// Runs a directed pass over the edge cases, then random passes at several
// sample periods, with random gaps on both sides and one long output hold.
// ----------------------------------------------------------------------------
module heart_rate_moving_average_tb;

    localparam int unsigned WINDOW       = 8;
    localparam int unsigned PHASE_ITEMS  = 250;
    localparam int unsigned HOLD_CYCLES  = 400;
    localparam int unsigned QUIET_LIMIT  = 4000;
    localparam int unsigned TAIL_CYCLES  = 80;
    localparam int unsigned GAP_PERCENT  = 17;

    typedef struct packed {
        logic [hrma_pkg::RATE_W-1:0] avg;
        logic                        zero;
    } bpm_result_t;

    // Scoreboard: own copy of the period, the rate ring and its running sum
    class beat_average_scoreboard;
        logic [hrma_pkg::PERIOD_W-1:0] period;
        logic [hrma_pkg::RATE_W-1:0]   rates [WINDOW];
        int unsigned                   slot;
        logic [18:0]                   total;
        bpm_result_t                   awaited [$];
        int unsigned                   fails;
        int unsigned                   n_results;
        int unsigned                   n_zero;
        int unsigned                   n_saturated;
        int unsigned                   n_rate_zero;

        function new();
            foreach (rates[i])
                rates[i] = '0;
            period      = hrma_pkg::PERIOD_RESET;
            slot        = 0;
            total       = '0;
            fails       = 0;
            n_results   = 0;
            n_zero      = 0;
            n_saturated = 0;
            n_rate_zero = 0;
        endfunction

        function void set_period(logic [hrma_pkg::PERIOD_W-1:0] p);
            period = p;
        endfunction

        function int unsigned pending();
            return awaited.size();
        endfunction

        // Round 60000/(interval*period) up from a fraction of 0.45
        function logic [hrma_pkg::RATE_W-1:0] rounded_rate(
            logic [hrma_pkg::INTERVAL_W-1:0] iv);
            logic [hrma_pkg::PROD_W-1:0] d;
            logic [63:0]                 q;
            d = iv * period;
            if (d == 0)
                return hrma_pkg::RATE_MAX;
            q = (64'(hrma_pkg::RATE_NUM_BASE) + 64'd11 * d) / (64'd20 * d);
            if (q > hrma_pkg::RATE_MAX)
                q = hrma_pkg::RATE_MAX;
            return q[hrma_pkg::RATE_W-1:0];
        endfunction

        // Replace the oldest rate and predict the new mean
        function void note_interval(logic [hrma_pkg::INTERVAL_W-1:0] iv);
            logic [hrma_pkg::RATE_W-1:0] rate;
            bpm_result_t                 res;
            rate = rounded_rate(iv);
            if (rate == hrma_pkg::RATE_MAX)
                n_saturated++;
            if (rate == 0)
                n_rate_zero++;
            if (iv == 0)
                n_zero++;
            total       = total - rates[slot] + rate;
            rates[slot] = rate;
            slot        = (slot + 1) % WINDOW;
            res.avg     = hrma_pkg::RATE_W'(total / WINDOW);
            res.zero    = (iv == 0);
            awaited.push_back(res);
        endfunction

        function void check_result(logic [hrma_pkg::RATE_W-1:0] avg, logic zero);
            bpm_result_t want;
            n_results++;
            if (awaited.size() == 0)
            begin
                $error("result with no prediction waiting: avg_bpm %0d zero_interval %0d",
                       avg, zero);
                fails++;
                return;
            end
            want = awaited.pop_front();
            if (avg !== want.avg)
            begin
                $error("avg_bpm: expected %0d, actual %0d", want.avg, avg);
                fails++;
            end
            if (zero !== want.zero)
            begin
                $error("zero_interval: expected %0d, actual %0d", want.zero, zero);
                fails++;
            end
        endfunction
    endclass

    logic                            clk;
    logic                            rst_n;
    logic                            cfg_we;
    logic [hrma_pkg::PERIOD_W-1:0]   cfg_wdata;
    logic                            in_valid;
    logic                            in_stall;
    logic [hrma_pkg::INTERVAL_W-1:0] interval_samples;
    logic                            out_valid;
    logic                            out_stall;
    logic [hrma_pkg::RATE_W-1:0]     avg_bpm;
    logic                            zero_interval;

    beat_average_scoreboard scoreboard = new();

    bit          gaps_on      = 1'b1;
    bit          hold_request = 1'b0;
    int unsigned hold_left    = 0;
    int unsigned items_sent   = 0;

    heart_rate_moving_average #(
        .WINDOW_SIZE (WINDOW)
    ) i_dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_we           (cfg_we),
        .cfg_wdata        (cfg_wdata),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .interval_samples (interval_samples),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .avg_bpm          (avg_bpm),
        .zero_interval    (zero_interval)
    );

    // 10 ns clock
    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // Receiver: random stalls, or a long hold when one is requested
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                hold_left    = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else
            begin
                out_stall <= gaps_on && ($urandom_range(99) < GAP_PERCENT);
            end
        end
    end

    // Check every output transfer
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            scoreboard.check_result(avg_bpm, zero_interval);
    end

    // Watchdog: end the run after too long without any transfer
    initial
    begin
        int unsigned quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet = 0;
            else
                quiet++;
        end
        $display("FAILURE");
        $finish;
    end

    // Offer one interval, sometimes after a random gap; called at a falling edge
    task automatic offer_interval(input logic [hrma_pkg::INTERVAL_W-1:0] iv);
        if (gaps_on && ($urandom_range(99) < GAP_PERCENT))
        begin
            in_valid <= 1'b0;
            @(negedge clk);
            while (gaps_on && ($urandom_range(99) < GAP_PERCENT))
                @(negedge clk);
        end
        in_valid         <= 1'b1;
        interval_samples <= iv;
        do
            @(posedge clk);
        while (!(in_valid && !in_stall));
        scoreboard.note_interval(iv);
        items_sent++;
        @(negedge clk);
    endtask

    // Drain every pending result, then write the sample period
    task automatic drain_and_set_period(input logic [hrma_pkg::PERIOD_W-1:0] p);
        in_valid <= 1'b0;
        while (scoreboard.pending() != 0)
            @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= p;
        @(negedge clk);
        cfg_we <= 1'b0;
        scoreboard.set_period(p);
    endtask

    // Mostly plausible heart rates for the period, plus zeros, tiny and wild values
    function automatic logic [hrma_pkg::INTERVAL_W-1:0] pick_interval(
        input logic [hrma_pkg::PERIOD_W-1:0] p);
        int unsigned roll;
        int unsigned bpm;
        int unsigned iv;
        roll = $urandom_range(99);
        if (roll < 5)
            return '0;
        if (roll < 15)
            return hrma_pkg::INTERVAL_W'($urandom_range(1, 16));
        if (roll < 70 && p != 0)
        begin
            bpm = $urandom_range(30, 220);
            iv  = 60000 / (bpm * p) + $urandom_range(0, 2);
            if (iv > 65535)
                iv = 65535;
            return hrma_pkg::INTERVAL_W'(iv);
        end
        return hrma_pkg::INTERVAL_W'($urandom());
    endfunction

    initial
    begin
        logic [hrma_pkg::PERIOD_W-1:0]   periods [7];
        logic [hrma_pkg::INTERVAL_W-1:0] warmup  [11];

        rst_n            = 1'b0;
        cfg_we           = 1'b0;
        cfg_wdata        = '0;
        in_valid         = 1'b0;
        interval_samples = '0;

        // Hold reset, then release it on a falling edge
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Warm-up at the reset period: zero, extremes, bit patterns, tiny rates
        warmup = '{16'd0, 16'd1, 16'd65535, 16'hAAAA, 16'h5555, 16'd100,
                   16'd75, 16'd60, 16'd120, 16'd6000, 16'd65535};
        foreach (warmup[i])
            offer_interval(warmup[i]);

        // Zero period: every rate saturates, flag only on a zero interval
        drain_and_set_period('0);
        offer_interval(16'd0);
        offer_interval(16'd1);
        offer_interval(16'd65535);
        offer_interval(16'd500);

        // Longest period in range and the all-ones register
        drain_and_set_period(10'd1000);
        offer_interval(16'd1);
        offer_interval(16'd65535);
        offer_interval(16'd0);
        offer_interval(16'd2);
        drain_and_set_period(10'h3FF);
        offer_interval(16'd1);
        offer_interval(16'd100);

        // Random passes over a spread of periods
        periods = '{10'd1, hrma_pkg::PERIOD_RESET, 10'd1000,
                    10'($urandom_range(1, 1000)), 10'd0, 10'h3FF,
                    10'($urandom_range(1, 1000))};
        foreach (periods[ph])
        begin
            drain_and_set_period(periods[ph]);
            gaps_on = (ph != 1);
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                // Long output hold so the block fills and stalls its input
                if (ph == 0 && n == 40)
                    hold_request = 1'b1;
                offer_interval(pick_interval(periods[ph]));
            end
        end
        gaps_on = 1'b1;

        // Drain and let the tail settle
        in_valid <= 1'b0;
        while (scoreboard.pending() != 0)
            @(negedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Checked %0d results from %0d beat intervals over ten period settings",
                 scoreboard.n_results, items_sent);
        $display("  including %0d zero intervals, %0d saturated and %0d zero rates",
                 scoreboard.n_zero, scoreboard.n_saturated, scoreboard.n_rate_zero);
        if (scoreboard.fails == 0 && scoreboard.pending() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
